// ===== rtl/core/blss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blss_pkg
// shared codes and types of the bounded list store with search
// ----------------------------------------------------------------------------
package blss_pkg;

  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_CLEAR  = 3'd2;
  localparam logic [2:0] ACT_SEARCH = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/bounded_list_store_with_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_store_with_search
// list of signed 32-bit entries in one synchronous ram, with append, remove
// last, clear, linear search and indexed read
// ----------------------------------------------------------------------------
// Usage: one operation enters per transfer on the in_ channel (action, value,
// position); each gives exactly one result on the out_ channel (read_value,
// found_index, status, entry_count). Entries live in a CAPACITY x 32 ram
// with a registered read port; the fill count is a register.
// Flow: append, remove, clear and unused codes go from S_IDLE straight to
// S_DONE; a read passes S_READ, where the ram data is taken, on its way to
// S_DONE; a search walks the entries in S_SEARCH, the ram delivering one
// entry per cycle to the compare, until a hit or the last entry, then goes
// to S_DONE, whence the result enters the output register. Only one item is
// in the block at a time: a new one is taken only in S_IDLE.
// Reset clears the fill count and the control state; the ram is not cleared.
// When the receiver stalls, the result is held in the output register and a
// finished item waits in its last state; in_stall stays high meanwhile.
// ----------------------------------------------------------------------------
module bounded_list_store_with_search #(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_value,
  input  logic [7:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_read_value,
  output logic [7:0]         out_found_index,
  output logic [2:0]         out_status,
  output logic [8:0]         out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 8) ? CW : 8;

  logic [31:0] mem [CAPACITY];
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [31:0] mem_rdata_r;

  blss_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic [CW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [31:0]   pend_rd_r, pend_rd_nxt;
  logic [7:0]    pend_idx_r, pend_idx_nxt;
  logic [2:0]    pend_st_r, pend_st_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_rd_r, out_rd_nxt;
  logic [7:0]    out_idx_r, out_idx_nxt;
  logic [2:0]    out_st_r, out_st_nxt;
  logic [8:0]    out_cnt_r, out_cnt_nxt;

  logic          accept;
  logic          out_free;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;

  assign accept   = in_valid && (state_r == blss_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign pos_ext  = PW'(in_position);
  assign cnt_ext  = PW'(count_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_value;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    iss_nxt       = iss_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_idx_nxt   = cmp_idx_r;
    val_nxt       = val_r;
    pend_rd_nxt   = pend_rd_r;
    pend_idx_nxt  = pend_idx_r;
    pend_st_nxt   = pend_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rd_nxt    = out_rd_r;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_raddr     = iss_r[AW-1:0];

    case (state_r)
      blss_pkg::S_IDLE: begin
        if (accept) begin
          pend_rd_nxt  = '0;
          pend_idx_nxt = '0;
          pend_st_nxt  = blss_pkg::ST_OK;
          val_nxt      = in_value;
          state_nxt    = blss_pkg::S_DONE;
          case (in_action)
            blss_pkg::ACT_APPEND: begin
              if (count_r >= CW'(CAPACITY)) begin
                pend_st_nxt = blss_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            blss_pkg::ACT_REMOVE: begin
              if (count_r == '0) begin
                pend_st_nxt = blss_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            blss_pkg::ACT_CLEAR: begin
              count_nxt = '0;
            end
            blss_pkg::ACT_SEARCH: begin
              iss_nxt   = '0;
              cmp_v_nxt = 1'b0;
              state_nxt = blss_pkg::S_SEARCH;
            end
            blss_pkg::ACT_READ: begin
              if (pos_ext < cnt_ext) begin
                mem_raddr = pos_ext[AW-1:0];
                state_nxt = blss_pkg::S_READ;
              end else begin
                pend_st_nxt = blss_pkg::ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      blss_pkg::S_READ: begin
        pend_rd_nxt = mem_rdata_r;
        state_nxt   = blss_pkg::S_DONE;
      end
      blss_pkg::S_SEARCH: begin
        if (cmp_v_r && (mem_rdata_r == val_r)) begin
          pend_idx_nxt = 8'(cmp_idx_r);
          state_nxt    = blss_pkg::S_DONE;
        end else if (iss_r < count_r) begin
          mem_raddr   = iss_r[AW-1:0];
          iss_nxt     = iss_r + 1'b1;
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = iss_r;
        end else begin
          pend_st_nxt = blss_pkg::ST_NOT_FOUND;
          state_nxt   = blss_pkg::S_DONE;
        end
      end
      blss_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = pend_rd_r;
          out_idx_nxt   = pend_idx_r;
          out_st_nxt    = pend_st_r;
          out_cnt_nxt   = 9'(count_r);
          state_nxt     = blss_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = blss_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blss_pkg::S_IDLE;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r      <= iss_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    val_r      <= val_nxt;
    pend_rd_r  <= pend_rd_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_st_r  <= pend_st_nxt;
    out_rd_r   <= out_rd_nxt;
    out_idx_r  <= out_idx_nxt;
    out_st_r   <= out_st_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_stall        = (state_r != blss_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_value  = out_rd_r;
  assign out_found_index = out_idx_r;
  assign out_status      = out_st_r;
  assign out_entry_count = out_cnt_r;

endmodule
